// File: sv/utbd_pkg.sv
// Shared constants, word types and a helper function for the base-digit converter.
package utbd_pkg;

  localparam int unsigned MAX_DIGITS  = 64;
  localparam int unsigned VALUE_WIDTH = 64;

  localparam int unsigned IN_VALUE_W = 64;
  localparam int unsigned MIN_LEN_W  = 7;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_W      = 8;

  localparam int unsigned ND_W    = $clog2(MAX_DIGITS + 1);
  localparam int unsigned POS_W   = $clog2(MAX_DIGITS);
  localparam int unsigned CHUNKS  = (VALUE_WIDTH + 7) / 8;
  localparam int unsigned CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned VW_PAD  = CHUNKS * 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET  = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] DIGIT_TEN    = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  LETTER_RESET = CHAR_W'(97);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = CHAR_W'(48);

  typedef enum logic {
    REG_RADIX  = 1'b0,
    REG_LETTER = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [MIN_LEN_W-1:0]  min_len;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [ND_W-1:0]        want;
    logic [RADIX_W-1:0]     base;
    logic [CHAR_W-1:0]      letter;
  } job_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic [CHAR_W-1:0]  letter);
    logic [CHAR_W-1:0] c;
    if (d >= DIGIT_TEN) begin
      c = letter + CHAR_W'(d) - CHAR_W'(DIGIT_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// File: sv/unsigned_to_base_digits.sv
// Top level of the unsigned value to base-digit character converter.
// Each accepted word (value, min_len) yields max(digits, min(min_len, 64)) characters, most
// significant first, the last one flagged. Per digit the engine passes through a setup state,
// then divides the remaining value byte by byte, from its highest nonzero byte down to byte 0.
// Characters then leave at one per cycle while pop keeps up, through the digit-store read
// register and the output queue. Two jobs queue ahead of the engine, and two characters
// wait at the output.
module unsigned_to_base_digits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  utbd_pkg::in_word_t            in_word_i,
  output logic                          empty,
  input  logic                          pop,
  output utbd_pkg::out_word_t           out_word_o,
  input  logic                          cfg_we_i,
  input  utbd_pkg::cfg_reg_e            cfg_idx_i,
  input  logic [utbd_pkg::CFG_W-1:0]    cfg_data_i
);
  import utbd_pkg::*;

  logic [RADIX_W-1:0] radix_q;
  logic [CHAR_W-1:0]  letter_q;
  job_t               front_job;
  job_t               queue_job;
  logic               job_valid;
  logic               job_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_RESET;
      letter_q <= LETTER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIX:  radix_q  <= cfg_data_i[RADIX_W-1:0];
        REG_LETTER: letter_q <= cfg_data_i[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  utbd_front u_front (
    .in_word_i (in_word_i),
    .radix_i   (radix_q),
    .letter_i  (letter_q),
    .job_o     (front_job)
  );

  utbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .job_o   (queue_job),
    .valid_o (job_valid),
    .pop_i   (job_pop)
  );

  utbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_pop_o   (job_pop),
    .job_i       (queue_job),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .out_word_o  (out_word_o)
  );

endmodule

// File: sv/utbd_front.sv
// Front end: classify an incoming word into a conversion job.
module utbd_front (
  input  utbd_pkg::in_word_t              in_word_i,
  input  logic [utbd_pkg::RADIX_W-1:0]    radix_i,
  input  logic [utbd_pkg::CHAR_W-1:0]     letter_i,
  output utbd_pkg::job_t                  job_o
);
  import utbd_pkg::*;

  always_comb begin
    job_o.value  = in_word_i.value[VALUE_WIDTH-1:0];
    if (in_word_i.min_len > MIN_LEN_W'(MAX_DIGITS)) begin
      job_o.want = ND_W'(MAX_DIGITS);
    end else begin
      job_o.want = ND_W'(in_word_i.min_len);
    end
    job_o.base   = (radix_i < RADIX_MIN) ? RADIX_MIN : radix_i;
    job_o.letter = letter_i;
  end

endmodule

// File: sv/utbd_queue.sv
// Two-entry job queue between the front end and the digit engine.
module utbd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  utbd_pkg::job_t  job_i,
  output logic            full_o,
  output utbd_pkg::job_t  job_o,
  output logic            valid_o,
  input  logic            pop_i
);
  import utbd_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

// File: sv/utbd_back.sv
// Digit engine: byte-serial division, digit store and character output queue.
module utbd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_pop_o,
  input  utbd_pkg::job_t     job_i,
  input  logic               out_pop_i,
  output logic               out_empty_o,
  output utbd_pkg::out_word_t out_word_o
);
  import utbd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_DIV   = 4'b0100,
    S_EMIT  = 4'b1000
  } back_state_e;

  back_state_e         state_q, state_d;
  logic [VW_PAD-1:0]   val_q, val_d;
  logic [RADIX_W-1:0]  rem_q, rem_d;
  logic [CHUNK_W-1:0]  chunk_q, chunk_d;
  logic [ND_W-1:0]     nd_q, nd_d;
  logic [ND_W-1:0]     want_q, want_d;
  logic [RADIX_W-1:0]  base_q, base_d;
  logic [CHAR_W-1:0]   letter_q, letter_d;
  logic [POS_W-1:0]    pos_q, pos_d;

  logic                p_valid_q, p_valid_d;
  logic                p_pad_q, p_pad_d;
  logic                p_last_q, p_last_d;
  logic [RADIX_W-1:0]  rd_q;
  logic [RADIX_W-1:0]  dig_mem [MAX_DIGITS];
  logic                dig_we, rd_en;

  out_word_t           fifo_q [2];
  logic                wptr_q, rptr_q;
  logic [1:0]          cnt_q, cnt_d;
  logic                deq;
  logic [2:0]          occ;
  logic                credit;

  logic [7:0]          div_byte;
  logic [7:0]          quo;
  logic [RADIX_W-1:0]  div_rem;
  logic [CHUNK_W-1:0]  top_chunk;
  logic [ND_W-1:0]     total;
  out_word_t           push_word;

  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [RADIX_W:0]   r2;
    r        = rem_q;
    div_byte = val_q[{chunk_q, 3'b000} +: 8];
    quo      = 8'd0;
    for (int i = 7; i >= 0; i--) begin
      r2 = {r, div_byte[i]};
      if (r2 >= {1'b0, base_q}) begin
        r2     = r2 - {1'b0, base_q};
        quo[i] = 1'b1;
      end
      r = r2[RADIX_W-1:0];
    end
    div_rem = r;
  end

  always_comb begin
    top_chunk = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (val_q[c*8 +: 8] != 8'd0) begin
        top_chunk = CHUNK_W'(c);
      end
    end
  end

  assign total  = (want_q > nd_q) ? want_q : nd_q;
  assign deq    = out_pop_i && (cnt_q != 2'd0);
  assign occ    = {1'b0, cnt_q} + {2'b00, p_valid_q} - {2'b00, deq};
  assign credit = (occ < 3'd2);

  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    rem_d     = rem_q;
    chunk_d   = chunk_q;
    nd_d      = nd_q;
    want_d    = want_q;
    base_d    = base_q;
    letter_d  = letter_q;
    pos_d     = pos_q;
    p_valid_d = 1'b0;
    p_pad_d   = p_pad_q;
    p_last_d  = p_last_q;
    dig_we    = 1'b0;
    rd_en     = 1'b0;
    job_pop_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          val_d     = VW_PAD'(job_i.value);
          want_d    = job_i.want;
          base_d    = job_i.base;
          letter_d  = job_i.letter;
          nd_d      = '0;
          state_d   = S_START;
        end
      end
      S_START: begin
        if ((nd_q != '0) && ((val_q == '0) || (nd_q == ND_W'(MAX_DIGITS)))) begin
          pos_d   = POS_W'(total - ND_W'(1));
          state_d = S_EMIT;
        end else begin
          chunk_d = top_chunk;
          rem_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        val_d[{chunk_q, 3'b000} +: 8] = quo;
        rem_d = div_rem;
        if (chunk_q == '0) begin
          dig_we  = 1'b1;
          nd_d    = nd_q + ND_W'(1);
          state_d = S_START;
        end else begin
          chunk_d = chunk_q - CHUNK_W'(1);
        end
      end
      S_EMIT: begin
        if (credit) begin
          p_valid_d = 1'b1;
          p_pad_d   = (ND_W'(pos_q) >= nd_q);
          p_last_d  = (pos_q == '0);
          rd_en     = 1'b1;
          if (pos_q == '0) begin
            state_d = S_IDLE;
          end else begin
            pos_d = pos_q - POS_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      p_valid_q <= 1'b0;
      wptr_q    <= 1'b0;
      rptr_q    <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      state_q   <= state_d;
      p_valid_q <= p_valid_d;
      wptr_q    <= p_valid_q ? ~wptr_q : wptr_q;
      rptr_q    <= deq ? ~rptr_q : rptr_q;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    rem_q    <= rem_d;
    chunk_q  <= chunk_d;
    nd_q     <= nd_d;
    want_q   <= want_d;
    base_q   <= base_d;
    letter_q <= letter_d;
    pos_q    <= pos_d;
    p_pad_q  <= p_pad_d;
    p_last_q <= p_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      dig_mem[nd_q[POS_W-1:0]] <= div_rem;
    end
    if (rd_en) begin
      rd_q <= dig_mem[pos_q];
    end
  end

  always_comb begin
    push_word.char_out = p_pad_q ? CHAR_ZERO : digit_char(rd_q, letter_q);
    push_word.last     = p_last_q;
    cnt_d              = cnt_q + 2'(p_valid_q) - 2'(deq);
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q) begin
      fifo_q[wptr_q] <= push_word;
    end
  end

  assign out_empty_o = (cnt_q == 2'd0);
  assign out_word_o  = fifo_q[rptr_q];

endmodule
